// ----- sv/etfp_pkg.sv -----
// ----------------------------------------------------------------------------
// etfp_pkg: shared definitions for the term frame parser
// Phase codes, tag bytes, result kinds, status codes and the types that
// carry parser state and one result between modules.
// ----------------------------------------------------------------------------
package etfp_pkg;

  localparam int unsigned KEY_CAPACITY = 32;
  localparam logic [31:0] KEY_CAP_W    = 32'(KEY_CAPACITY);

  localparam logic [4:0] PH_MAGIC  = 5'd0;
  localparam logic [4:0] PH_RESYNC = 5'd1;
  localparam logic [4:0] PH_TTAG   = 5'd2;
  localparam logic [4:0] PH_ARITY  = 5'd3;
  localparam logic [4:0] PH_KTAG   = 5'd4;
  localparam logic [4:0] PH_KLEN   = 5'd5;
  localparam logic [4:0] PH_KBYTES = 5'd6;
  localparam logic [4:0] PH_VTAG   = 5'd7;
  localparam logic [4:0] PH_SMALL  = 5'd8;
  localparam logic [4:0] PH_INT    = 5'd9;
  localparam logic [4:0] PH_VLEN   = 5'd10;
  localparam logic [4:0] PH_BBYTES = 5'd11;
  localparam logic [4:0] PH_SBYTES = 5'd12;
  localparam logic [4:0] PH_LTAG   = 5'd13;
  localparam logic [4:0] PH_LSMALL = 5'd14;
  localparam logic [4:0] PH_LINT   = 5'd15;
  localparam logic [4:0] PH_LNIL   = 5'd16;

  localparam logic [7:0] TAG_MAGIC     = 8'd131;
  localparam logic [7:0] TAG_SMALL_INT = 8'd97;
  localparam logic [7:0] TAG_INT       = 8'd98;
  localparam logic [7:0] TAG_TUPLE     = 8'd104;
  localparam logic [7:0] TAG_NIL       = 8'd106;
  localparam logic [7:0] TAG_STRING    = 8'd107;
  localparam logic [7:0] TAG_LIST      = 8'd108;
  localparam logic [7:0] TAG_BINARY    = 8'd109;

  localparam logic [1:0] VT_NONE = 2'd0;
  localparam logic [1:0] VT_BLOB = 2'd1;
  localparam logic [1:0] VT_STR  = 2'd2;
  localparam logic [1:0] VT_LIST = 2'd3;

  localparam logic [2:0] KIND_KEY   = 3'd0;
  localparam logic [2:0] KIND_INT   = 3'd1;
  localparam logic [2:0] KIND_LIST  = 3'd2;
  localparam logic [2:0] KIND_BLOB  = 3'd3;
  localparam logic [2:0] KIND_STR   = 3'd4;
  localparam logic [2:0] KIND_END   = 3'd5;
  localparam logic [2:0] KIND_ERROR = 3'd6;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_MAGIC   = 3'd1;
  localparam logic [2:0] ST_NOT_TUPLE   = 3'd2;
  localparam logic [2:0] ST_BAD_ARITY   = 3'd3;
  localparam logic [2:0] ST_BAD_TAG     = 3'd4;
  localparam logic [2:0] ST_KEY_TOO_LONG = 3'd5;
  localparam logic [2:0] ST_UNKNOWN     = 3'd6;

  typedef struct packed {
    logic [4:0]  phase;
    logic [1:0]  element_count;
    logic [1:0]  value_tag;
    logic [1:0]  byte_step;
    logic [31:0] word;
    logic [31:0] remaining;
    logic [31:0] position;
  } state_t;

  typedef struct packed {
    logic        valid;
    logic [2:0]  kind;
    logic [31:0] value;
    logic [31:0] index;
    logic [1:0]  tuple_size;
    logic        done;
    logic [2:0]  status;
  } res_t;

  function automatic res_t mk_res(logic [2:0] kind, logic [31:0] value,
                                  logic [31:0] index, logic done,
                                  logic [2:0] status);
    res_t r;
    r.valid      = 1'b1;
    r.kind       = kind;
    r.value      = value;
    r.index      = index;
    r.tuple_size = 2'd0;
    r.done       = done;
    r.status     = status;
    return r;
  endfunction

endpackage

// ----- sv/etfp_parser.sv -----
// ----------------------------------------------------------------------------
// etfp_parser: one byte step of the term parser
// Computes the next parser state and the optional result for one byte.
// ----------------------------------------------------------------------------
module etfp_parser (
  input  logic [7:0]       data_byte,
  input  etfp_pkg::state_t st,
  output etfp_pkg::state_t st_nxt,
  output etfp_pkg::res_t   res
);

  logic [31:0] word_nxt;
  logic [31:0] rem_dec;
  logic [31:0] pos_inc;
  logic        run_last;
  logic        vlen_done;

  assign word_nxt  = {st.word[23:0], data_byte};
  assign rem_dec   = st.remaining - 32'd1;
  assign pos_inc   = st.position + 32'd1;
  assign run_last  = (rem_dec == 32'd0);
  assign vlen_done = (st.value_tag == etfp_pkg::VT_STR) ? (st.byte_step != 2'd0)
                                                         : (st.byte_step == 2'd3);

  always_comb begin
    st_nxt = st;
    res    = '0;
    case (st.phase)
      etfp_pkg::PH_MAGIC, etfp_pkg::PH_RESYNC: begin
        if (data_byte == etfp_pkg::TAG_MAGIC) begin
          st_nxt       = '0;
          st_nxt.phase = etfp_pkg::PH_TTAG;
        end else if (st.phase == etfp_pkg::PH_MAGIC) begin
          st_nxt.element_count = 2'd0;
          st_nxt.phase         = etfp_pkg::PH_RESYNC;
          res = etfp_pkg::mk_res(etfp_pkg::KIND_ERROR, '0, '0, 1'b1,
                                 etfp_pkg::ST_BAD_MAGIC);
        end
      end
      etfp_pkg::PH_TTAG: begin
        if (data_byte != etfp_pkg::TAG_TUPLE) begin
          st_nxt.phase = etfp_pkg::PH_RESYNC;
          res = etfp_pkg::mk_res(etfp_pkg::KIND_ERROR, '0, '0, 1'b1,
                                 etfp_pkg::ST_NOT_TUPLE);
        end else begin
          st_nxt.phase = etfp_pkg::PH_ARITY;
        end
      end
      etfp_pkg::PH_ARITY: begin
        if (data_byte > 8'd2) begin
          st_nxt.phase = etfp_pkg::PH_RESYNC;
          res = etfp_pkg::mk_res(etfp_pkg::KIND_ERROR, '0, '0, 1'b1,
                                 etfp_pkg::ST_BAD_ARITY);
        end else begin
          st_nxt.element_count = data_byte[1:0];
          if (data_byte == 8'd0) begin
            st_nxt.phase = etfp_pkg::PH_MAGIC;
            res = etfp_pkg::mk_res(etfp_pkg::KIND_END, '0, '0, 1'b1, etfp_pkg::ST_OK);
          end else begin
            st_nxt.phase = etfp_pkg::PH_KTAG;
          end
        end
      end
      etfp_pkg::PH_KTAG: begin
        if (data_byte != etfp_pkg::TAG_BINARY) begin
          st_nxt.phase = etfp_pkg::PH_RESYNC;
          res = etfp_pkg::mk_res(etfp_pkg::KIND_ERROR, '0, '0, 1'b1,
                                 etfp_pkg::ST_BAD_TAG);
        end else begin
          st_nxt.byte_step = 2'd0;
          st_nxt.word      = '0;
          st_nxt.phase     = etfp_pkg::PH_KLEN;
        end
      end
      etfp_pkg::PH_KLEN: begin
        st_nxt.word = word_nxt;
        if (st.byte_step == 2'd3) begin
          st_nxt.byte_step = 2'd0;
          if (word_nxt > etfp_pkg::KEY_CAP_W) begin
            st_nxt.phase = etfp_pkg::PH_RESYNC;
            res = etfp_pkg::mk_res(etfp_pkg::KIND_ERROR, '0, '0, 1'b1,
                                   etfp_pkg::ST_KEY_TOO_LONG);
          end else if (word_nxt == 32'd0) begin
            if (st.element_count == 2'd1) begin
              st_nxt.phase = etfp_pkg::PH_MAGIC;
              res = etfp_pkg::mk_res(etfp_pkg::KIND_END, '0, '0, 1'b1, etfp_pkg::ST_OK);
            end else begin
              st_nxt.phase = etfp_pkg::PH_VTAG;
            end
          end else begin
            st_nxt.remaining = word_nxt;
            st_nxt.position  = '0;
            st_nxt.phase     = etfp_pkg::PH_KBYTES;
          end
        end else begin
          st_nxt.byte_step = st.byte_step + 2'd1;
        end
      end
      etfp_pkg::PH_KBYTES: begin
        st_nxt.position  = pos_inc;
        st_nxt.remaining = rem_dec;
        res = etfp_pkg::mk_res(etfp_pkg::KIND_KEY, {24'd0, data_byte}, st.position,
                               1'b0, etfp_pkg::ST_OK);
        if (run_last) begin
          if (st.element_count == 2'd1) begin
            st_nxt.phase = etfp_pkg::PH_MAGIC;
            res.done     = 1'b1;
          end else begin
            st_nxt.phase = etfp_pkg::PH_VTAG;
          end
        end
      end
      etfp_pkg::PH_VTAG: begin
        st_nxt.byte_step = 2'd0;
        st_nxt.word      = '0;
        case (data_byte)
          etfp_pkg::TAG_NIL: begin
            st_nxt.byte_step = st.byte_step;
            st_nxt.word      = st.word;
            st_nxt.phase     = etfp_pkg::PH_MAGIC;
            res = etfp_pkg::mk_res(etfp_pkg::KIND_END, '0, '0, 1'b1, etfp_pkg::ST_OK);
          end
          etfp_pkg::TAG_SMALL_INT: begin
            st_nxt.byte_step = st.byte_step;
            st_nxt.word      = st.word;
            st_nxt.phase     = etfp_pkg::PH_SMALL;
          end
          etfp_pkg::TAG_INT: begin
            st_nxt.phase = etfp_pkg::PH_INT;
          end
          etfp_pkg::TAG_BINARY: begin
            st_nxt.value_tag = etfp_pkg::VT_BLOB;
            st_nxt.phase     = etfp_pkg::PH_VLEN;
          end
          etfp_pkg::TAG_STRING: begin
            st_nxt.value_tag = etfp_pkg::VT_STR;
            st_nxt.phase     = etfp_pkg::PH_VLEN;
          end
          etfp_pkg::TAG_LIST: begin
            st_nxt.value_tag = etfp_pkg::VT_LIST;
            st_nxt.phase     = etfp_pkg::PH_VLEN;
          end
          default: begin
            st_nxt.byte_step = st.byte_step;
            st_nxt.word      = st.word;
            st_nxt.phase     = etfp_pkg::PH_RESYNC;
            res = etfp_pkg::mk_res(etfp_pkg::KIND_ERROR, '0, '0, 1'b1,
                                   etfp_pkg::ST_BAD_TAG);
          end
        endcase
      end
      etfp_pkg::PH_SMALL: begin
        st_nxt.phase = etfp_pkg::PH_MAGIC;
        res = etfp_pkg::mk_res(etfp_pkg::KIND_INT, {24'd0, data_byte}, '0, 1'b1,
                               etfp_pkg::ST_OK);
      end
      etfp_pkg::PH_INT: begin
        st_nxt.word = word_nxt;
        if (st.byte_step == 2'd3) begin
          st_nxt.byte_step = 2'd0;
          st_nxt.phase     = etfp_pkg::PH_MAGIC;
          res = etfp_pkg::mk_res(etfp_pkg::KIND_INT, word_nxt, '0, 1'b1, etfp_pkg::ST_OK);
        end else begin
          st_nxt.byte_step = st.byte_step + 2'd1;
        end
      end
      etfp_pkg::PH_VLEN: begin
        st_nxt.word = word_nxt;
        if (vlen_done) begin
          st_nxt.byte_step = 2'd0;
          if (word_nxt == 32'd0) begin
            st_nxt.phase = etfp_pkg::PH_RESYNC;
            res = etfp_pkg::mk_res(etfp_pkg::KIND_ERROR, '0, '0, 1'b1,
                                   etfp_pkg::ST_UNKNOWN);
          end else begin
            st_nxt.remaining = word_nxt;
            st_nxt.position  = '0;
            if (st.value_tag == etfp_pkg::VT_BLOB) begin
              st_nxt.phase = etfp_pkg::PH_BBYTES;
            end else if (st.value_tag == etfp_pkg::VT_STR) begin
              st_nxt.phase = etfp_pkg::PH_SBYTES;
            end else begin
              st_nxt.phase = etfp_pkg::PH_LTAG;
            end
          end
        end else begin
          st_nxt.byte_step = st.byte_step + 2'd1;
        end
      end
      etfp_pkg::PH_BBYTES, etfp_pkg::PH_SBYTES: begin
        st_nxt.position  = pos_inc;
        st_nxt.remaining = rem_dec;
        res = etfp_pkg::mk_res((st.phase == etfp_pkg::PH_BBYTES) ? etfp_pkg::KIND_BLOB
                                                                 : etfp_pkg::KIND_STR,
                               {24'd0, data_byte}, st.position, run_last,
                               etfp_pkg::ST_OK);
        if (run_last) begin
          st_nxt.phase = etfp_pkg::PH_MAGIC;
        end
      end
      etfp_pkg::PH_LTAG: begin
        if (data_byte == etfp_pkg::TAG_SMALL_INT) begin
          st_nxt.phase = etfp_pkg::PH_LSMALL;
        end else if (data_byte == etfp_pkg::TAG_INT) begin
          st_nxt.byte_step = 2'd0;
          st_nxt.word      = '0;
          st_nxt.phase     = etfp_pkg::PH_LINT;
        end else begin
          st_nxt.phase = etfp_pkg::PH_RESYNC;
          res = etfp_pkg::mk_res(etfp_pkg::KIND_ERROR, '0, '0, 1'b1,
                                 etfp_pkg::ST_BAD_TAG);
        end
      end
      etfp_pkg::PH_LSMALL: begin
        st_nxt.position  = pos_inc;
        st_nxt.remaining = rem_dec;
        st_nxt.phase     = run_last ? etfp_pkg::PH_LNIL : etfp_pkg::PH_LTAG;
        res = etfp_pkg::mk_res(etfp_pkg::KIND_LIST, {24'd0, data_byte}, st.position,
                               1'b0, etfp_pkg::ST_OK);
      end
      etfp_pkg::PH_LINT: begin
        st_nxt.word = word_nxt;
        if (st.byte_step == 2'd3) begin
          st_nxt.byte_step = 2'd0;
          st_nxt.position  = pos_inc;
          st_nxt.remaining = rem_dec;
          st_nxt.phase     = run_last ? etfp_pkg::PH_LNIL : etfp_pkg::PH_LTAG;
          res = etfp_pkg::mk_res(etfp_pkg::KIND_LIST, word_nxt, st.position, 1'b0,
                                 etfp_pkg::ST_OK);
        end else begin
          st_nxt.byte_step = st.byte_step + 2'd1;
        end
      end
      etfp_pkg::PH_LNIL: begin
        if (data_byte != etfp_pkg::TAG_NIL) begin
          st_nxt.phase = etfp_pkg::PH_RESYNC;
          res = etfp_pkg::mk_res(etfp_pkg::KIND_ERROR, '0, '0, 1'b1,
                                 etfp_pkg::ST_BAD_TAG);
        end else begin
          st_nxt.phase = etfp_pkg::PH_MAGIC;
          res = etfp_pkg::mk_res(etfp_pkg::KIND_END, '0, '0, 1'b1, etfp_pkg::ST_OK);
        end
      end
      default: begin
        st_nxt.phase = etfp_pkg::PH_RESYNC;
      end
    endcase
    res.tuple_size = st_nxt.element_count;
  end

endmodule

// ----- sv/etfp_out_reg.sv -----
// ----------------------------------------------------------------------------
// etfp_out_reg: result register
// Holds one result until the downstream side takes the transfer.
// ----------------------------------------------------------------------------
module etfp_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  etfp_pkg::res_t res_in,
  input  logic           out_stall,
  output logic           free,
  output logic           out_valid,
  output etfp_pkg::res_t res_out
);

  logic           valid_r;
  logic           valid_nxt;
  etfp_pkg::res_t res_r;

  assign free      = !valid_r || !out_stall;
  assign valid_nxt = load ? 1'b1 : (free ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

// ----- sv/erlang_term_frame_parser_top.sv -----
// ----------------------------------------------------------------------------
// erlang_term_frame_parser_top: external term frame parser
// Parses a byte stream of small tuple messages into key, value and element
// results, one byte per cycle while in_stall is low.
//
//   channel  dir  ports
//   in       in   in_valid, in_stall, in_data_byte
//   out      out  out_valid, out_stall, out_item_kind .. out_status_code
//
// One byte is accepted per cycle unless in_stall is high; the byte and its
// result, if any, pass through the input register, then the result register.
// Sync reset returns the parser to waiting for the magic byte.
// A stalled result holds in the result register; bytes that give no result
// still advance while the result waits.
// ----------------------------------------------------------------------------
module erlang_term_frame_parser_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_item_kind,
  output logic signed [31:0] out_item_value,
  output logic [31:0]        out_item_index,
  output logic [1:0]         out_tuple_size,
  output logic               out_term_done,
  output logic [2:0]         out_status_code
);

  logic             s1_valid_r;
  logic             s1_valid_nxt;
  logic [7:0]       s1_byte_r;
  logic             in_xfer;
  logic             advance;
  logic             out_free;
  etfp_pkg::state_t state_r;
  etfp_pkg::state_t state_nxt;
  etfp_pkg::res_t   res;
  etfp_pkg::res_t   res_out;

  etfp_parser u_parser (
    .data_byte (s1_byte_r),
    .st        (state_r),
    .st_nxt    (state_nxt),
    .res       (res)
  );

  etfp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && res.valid),
    .res_in    (res),
    .out_stall (out_stall),
    .free      (out_free),
    .out_valid (out_valid),
    .res_out   (res_out)
  );

  assign advance      = s1_valid_r && (!res.valid || out_free);
  assign in_stall     = s1_valid_r && !advance;
  assign in_xfer      = in_valid && !in_stall;
  assign s1_valid_nxt = in_xfer ? 1'b1 : (advance ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      state_r    <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_data_byte;
    end
  end

  assign out_item_kind   = res_out.kind;
  assign out_item_value  = $signed(res_out.value);
  assign out_item_index  = res_out.index;
  assign out_tuple_size  = res_out.tuple_size;
  assign out_term_done   = res_out.done;
  assign out_status_code = res_out.status;

  a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_kind == etfp_pkg::KIND_ERROR |-> out_term_done)
    else $error("error result without term end");

  a_status_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status_code != etfp_pkg::ST_OK |->
      out_item_kind == etfp_pkg::KIND_ERROR)
    else $error("nonzero status on a non-error result");

  a_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && res.valid && out_valid && out_stall |-> in_stall && !advance)
    else $error("byte advanced while its result had no room");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> state_r.phase == etfp_pkg::PH_MAGIC && !out_valid && !s1_valid_r)
    else $error("reset did not return to magic wait");

endmodule
